// ----- sv/islc_pkg.sv -----
package islc_pkg;

	localparam int DEF_MAX_COLS  = 1024;
	localparam int DEF_MAX_ROWS  = 1024;
	localparam int DEF_FRAC_BITS = 16;

	localparam int SAMPLE_W  = 16;
	localparam int CFG_LEN_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int KIND_W    = 2;

	// start point sits at column 0.0001, rounded to the fraction grid
	localparam longint unsigned START_ROUND = 64'd5000;
	localparam longint unsigned START_SCALE = 64'd10000;

	localparam logic [CFG_LEN_W-1:0] DEF_ROW_LENGTH = CFG_LEN_W'(1024);
	localparam logic [CFG_LEN_W-1:0] DEF_ROW_COUNT  = CFG_LEN_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL      = 2'd0,
		REG_ROW_LENGTH = 2'd1,
		REG_ROW_COUNT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CROSS = 2'd0,
		KIND_START = 2'd1,
		KIND_END   = 2'd2
	} point_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/iso_level_row_crossings.sv -----
// Finds where each grid row crosses an iso level. Samples (signed Q8.8) stream in row-major
// order; per row the block reports a start point when the first sample is above the level, a
// linearly interpolated crossing between every pair of neighbors that strictly straddle the
// level, and an end point when the last sample is above it. At most two points follow one
// sample, delivered in that order with tlast on the final one. For a crossing, the serial
// restoring divider first forms the column fraction, FRAC_BITS quotient bits (16 by default),
// before any point of that sample is handed out. Input is taken only while no earlier sample
// is still being worked on or waiting on the output. Configuration writes are taken in any
// cycle but belong to idle periods; a zero row length or row count acts as one, larger values
// clip to MAX_COLS and MAX_ROWS.
module iso_level_row_crossings #(
	parameter int MAX_COLS  = islc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS  = islc_pkg::DEF_MAX_ROWS,
	parameter int FRAC_BITS = islc_pkg::DEF_FRAC_BITS,
	localparam int CW = $clog2(MAX_COLS),
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int OUT_W = ((CW + FRAC_BITS + RW + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [islc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [islc_pkg::SAMPLE_W-1:0]       cfg_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [islc_pkg::SAMPLE_W-1:0]       s_tdata,   // sample
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [OUT_W-1:0]                    m_tdata,   // col_whole, col_frac, row_index
	output logic [islc_pkg::KIND_W-1:0]         m_tuser,   // point_kind
	output logic                                m_tlast
);

	localparam int SW = islc_pkg::SAMPLE_W;
	localparam int LW = (CW + 1 > islc_pkg::CFG_LEN_W) ? CW + 1 : islc_pkg::CFG_LEN_W;
	localparam int HW = (RW + 1 > islc_pkg::CFG_LEN_W) ? RW + 1 : islc_pkg::CFG_LEN_W;
	localparam longint unsigned START_NUM = (64'd1 << FRAC_BITS) + islc_pkg::START_ROUND;
	localparam logic [FRAC_BITS-1:0] START_FRAC =
		FRAC_BITS'(START_NUM / islc_pkg::START_SCALE);

	islc_pkg::state_t state_q, state_d;
	logic div_start;
	logic div_done;

	logic signed [SW-1:0]                 level_q;
	logic [islc_pkg::CFG_LEN_W-1:0]       row_length_q;
	logic [islc_pkg::CFG_LEN_W-1:0]       row_count_q;
	logic signed [SW-1:0]                 prev_q;
	logic [CW-1:0]                        col_q;
	logic [RW-1:0]                        row_q;

	// captured per transaction
	logic [CW-1:0]        pt_col_q;
	logic [RW-1:0]        pt_row_q;
	logic [CW-1:0]        pt_end_col_q;
	logic                 pend_start_q, pend_cross_q, pend_end_q;

	logic                 s_acc, m_acc;
	logic signed [SW-1:0] d1;
	logic [LW-1:0]        len_ext, len_eff, col_ext, col_inc;
	logic [HW-1:0]        rows_ext, rows_eff, row_inc;
	logic                 hit_start, hit_cross, hit_end, above;
	logic signed [SW:0]   num_s, den_s;
	logic [SW:0]          num_abs, den_abs;
	logic [FRAC_BITS-1:0] quo;
	logic                 last_point;

	logic [CW-1:0]        o_col;
	logic [FRAC_BITS-1:0] o_frac;
	islc_pkg::point_kind_t o_kind;

	assign cfg_ready = 1'b1;
	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// effective bounds
	assign len_ext = LW'(row_length_q);
	assign len_eff = (row_length_q == '0) ? LW'(1) :
		(len_ext > LW'(MAX_COLS)) ? LW'(MAX_COLS) : len_ext;
	assign rows_ext = HW'(row_count_q);
	assign rows_eff = (row_count_q == '0) ? HW'(1) :
		(rows_ext > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : rows_ext;
	assign col_ext = LW'(col_q);
	assign col_inc = col_ext + LW'(1);
	assign row_inc = HW'(row_q) + HW'(1);

	assign d1 = signed'(s_tdata);
	assign above = d1 > level_q;
	assign hit_start = (col_q == '0) && above;
	assign hit_cross = (col_q != '0) &&
		(((prev_q > level_q) && (d1 < level_q)) || ((prev_q < level_q) && (d1 > level_q)));
	assign hit_end = (col_ext == len_eff - LW'(1)) && above;

	assign num_s   = {level_q[SW-1], level_q} - {prev_q[SW-1], prev_q};
	assign den_s   = {d1[SW-1], d1} - {prev_q[SW-1], prev_q};
	assign num_abs = num_s[SW] ? -num_s : num_s;
	assign den_abs = den_s[SW] ? -den_s : den_s;

	islc_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_abs[SW-1:0]),
		.den   (den_abs[SW-1:0]),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			row_length_q <= islc_pkg::DEF_ROW_LENGTH;
			row_count_q  <= islc_pkg::DEF_ROW_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (islc_pkg::cfg_reg_t'(cfg_index))
				islc_pkg::REG_LEVEL:      level_q <= signed'(cfg_data);
				islc_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data[islc_pkg::CFG_LEN_W-1:0];
				islc_pkg::REG_ROW_COUNT:  row_count_q <= cfg_data[islc_pkg::CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= islc_pkg::ST_IDLE;
			prev_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
			pend_start_q <= 1'b0;
			pend_cross_q <= 1'b0;
			pend_end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				prev_q       <= d1;
				pend_start_q <= hit_start;
				pend_cross_q <= hit_cross;
				pend_end_q   <= hit_end;
				if (col_inc >= len_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= rows_eff) ? '0 : row_inc[RW-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end else if (m_acc) begin
				// drop the point just handed out
				priority if (pend_start_q) begin
					pend_start_q <= 1'b0;
				end else if (pend_cross_q) begin
					pend_cross_q <= 1'b0;
				end else begin
					pend_end_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pt_col_q     <= col_q - CW'(1);
			pt_row_q     <= row_q;
			pt_end_col_q <= len_eff[CW-1:0] - CW'(1);
		end
	end

	always_comb begin
		last_point = 1'b0;
		o_col      = pt_end_col_q;
		o_frac     = '0;
		o_kind     = islc_pkg::KIND_END;
		priority if (pend_start_q) begin
			o_col      = '0;
			o_frac     = START_FRAC;
			o_kind     = islc_pkg::KIND_START;
			last_point = !pend_cross_q && !pend_end_q;
		end else if (pend_cross_q) begin
			o_col      = pt_col_q;
			o_frac     = quo;
			o_kind     = islc_pkg::KIND_CROSS;
			last_point = !pend_end_q;
		end else begin
			last_point = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			islc_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (hit_cross) begin
						state_d = islc_pkg::ST_DIV;
					end else if (hit_start || hit_end) begin
						state_d = islc_pkg::ST_EMIT;
					end
				end
			end
			islc_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = islc_pkg::ST_EMIT;
				end
			end
			islc_pkg::ST_EMIT: begin
				if (m_acc && last_point) begin
					state_d = islc_pkg::ST_IDLE;
				end
			end
			default: state_d = islc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			islc_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				div_start = s_tvalid && hit_cross;
			end
			islc_pkg::ST_DIV: ;
			islc_pkg::ST_EMIT: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = OUT_W'({pt_row_q, o_frac, o_col});
	assign m_tuser = o_kind;
	assign m_tlast = last_point;

endmodule

// ----- sv/islc_div.sv -----
module islc_div #(
	parameter int FRAC_BITS = islc_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [islc_pkg::SAMPLE_W-1:0] num,
	input  logic [islc_pkg::SAMPLE_W-1:0] den,
	output logic                          done,
	output logic [FRAC_BITS-1:0]          quo
);

	localparam int NW = islc_pkg::SAMPLE_W;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [NW-1:0]        rem_q;
	logic [NW-1:0]        den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;

	logic [NW:0] rem_sh;
	logic [NW:0] rem_sub;
	logic        fits;

	// one quotient bit per cycle; remainder stays below the divisor
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign quo  = quo_q;

endmodule

// ----- test/tb_iso_level_row_crossings.sv -----
module tb_iso_level_row_crossings;

	localparam int MAX_COLS   = islc_pkg::DEF_MAX_COLS;
	localparam int MAX_ROWS   = islc_pkg::DEF_MAX_ROWS;
	localparam int FRAC_BITS  = islc_pkg::DEF_FRAC_BITS;
	localparam int CW         = 10;
	localparam int RW         = 10;
	localparam int OUT_W      = ((CW + FRAC_BITS + RW + 7) / 8) * 8;
	localparam int RAND_ITEMS = 1650;
	localparam int DRAIN_LAT  = FRAC_BITS + 8;
	localparam int LIMIT      = 1000000;
	// 0.0001 on a 16-bit fraction grid, rounded
	localparam logic [15:0] START_FRAC = 16'd7;

	typedef struct packed {
		logic [CW-1:0]         col_whole;
		logic [15:0]           col_frac;
		logic [RW-1:0]         row_index;
		islc_pkg::point_kind_t kind;
		logic                  last;
	} point_t;

	typedef struct packed {
		logic               is_cfg;
		islc_pkg::cfg_reg_t sel;
		logic [15:0]        value;
		logic               known;
		logic [1:0]         known_n;
		point_t             k0;
		point_t             k1;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [islc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [islc_pkg::SAMPLE_W-1:0]  cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [islc_pkg::SAMPLE_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [OUT_W-1:0]               m_tdata;
	logic [islc_pkg::KIND_W-1:0]    m_tuser;
	logic                           m_tlast;

	iso_level_row_crossings u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// shadow of the block's registers and counters
	logic signed [15:0] lvl;
	logic [10:0]        row_len_q;
	logic [10:0]        row_cnt_q;
	logic signed [15:0] prev_smp;
	int unsigned        col_ctr;
	int unsigned        row_ctr;

	point_t      pending_points[$];
	point_t      fresh[0:1];
	int          fresh_n;
	stim_row_t   stim_rows[$];
	int          fail_count;
	int          samples_sent;
	logic        calm;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %0s: got %0h want %0h", what, got, want);
		fail_count++;
	endtask

	function automatic point_t mk_point(input logic [CW-1:0] whole, input logic [15:0] frac,
			input logic [RW-1:0] row, input islc_pkg::point_kind_t kind, input logic last);
		point_t p;
		p.col_whole = whole;
		p.col_frac  = frac;
		p.row_index = row;
		p.kind      = kind;
		p.last      = last;
		return p;
	endfunction

	task automatic predict_points(input logic signed [15:0] d1);
		int unsigned len;
		int unsigned rows;
		int          num;
		int          den;
		int unsigned un;
		int unsigned ud;
		longint unsigned q;
		fresh_n = 0;
		len  = (row_len_q == 0) ? 1 : ((row_len_q > MAX_COLS) ? MAX_COLS : row_len_q);
		rows = (row_cnt_q == 0) ? 1 : ((row_cnt_q > MAX_ROWS) ? MAX_ROWS : row_cnt_q);
		if (col_ctr == 0 && d1 > lvl) begin
			fresh[fresh_n] = mk_point('0, START_FRAC, RW'(row_ctr), islc_pkg::KIND_START, 1'b0);
			fresh_n++;
		end
		if (col_ctr > 0 && ((prev_smp > lvl && d1 < lvl) || (prev_smp < lvl && d1 > lvl))) begin
			num = int'(lvl) - int'(prev_smp);
			den = int'(d1) - int'(prev_smp);
			un  = (num < 0) ? -num : num;
			ud  = (den < 0) ? -den : den;
			q   = (64'(un) << FRAC_BITS) / 64'(ud);
			fresh[fresh_n] = mk_point(CW'(col_ctr - 1), 16'(q), RW'(row_ctr),
				islc_pkg::KIND_CROSS, 1'b0);
			fresh_n++;
		end
		// a counter left past a shrunken row length gives no end point
		if (col_ctr == len - 1 && d1 > lvl) begin
			fresh[fresh_n] = mk_point(CW'(len - 1), '0, RW'(row_ctr), islc_pkg::KIND_END, 1'b0);
			fresh_n++;
		end
		if (fresh_n > 0) begin
			fresh[fresh_n - 1].last = 1'b1;
		end
		prev_smp = d1;
		if (col_ctr + 1 >= len) begin
			col_ctr = 0;
			row_ctr = (row_ctr + 1 >= rows) ? 0 : row_ctr + 1;
		end else begin
			col_ctr++;
		end
	endtask

	// enters and leaves at a falling edge
	task automatic send_sample(input logic [15:0] val, input logic known,
			input logic [1:0] known_n, input point_t k0, input point_t k1);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < 38) gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		predict_points(val);
		if (known) begin
			if (known_n >= 1) pending_points = {pending_points, k0};
			if (known_n >= 2) pending_points = {pending_points, k1};
		end else begin
			for (int i = 0; i < fresh_n; i++) pending_points = {pending_points, fresh[i]};
		end
		@(negedge clk);
	endtask

	task automatic cfg_write(input islc_pkg::cfg_reg_t sel, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			islc_pkg::REG_LEVEL:      lvl = val;
			islc_pkg::REG_ROW_LENGTH: row_len_q = val[10:0];
			islc_pkg::REG_ROW_COUNT:  row_cnt_q = val[10:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// sample-only items leave no trace, so give the block time to go idle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_LAT) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic void add_cfg(input islc_pkg::cfg_reg_t sel, input logic [15:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.sel    = sel;
		r.value  = val;
		stim_rows = {stim_rows, r};
	endfunction

	function automatic void add_smp(input logic [15:0] val);
		stim_row_t r;
		r = '0;
		r.value = val;
		stim_rows = {stim_rows, r};
	endfunction

	function automatic void add_known(input logic [15:0] val, input logic [1:0] n,
			input point_t k0, input point_t k1);
		stim_row_t r;
		r = '0;
		r.value   = val;
		r.known   = 1'b1;
		r.known_n = n;
		r.k0      = k0;
		r.k1      = k1;
		stim_rows = {stim_rows, r};
	endfunction

	// mostly near the level so that neighbors straddle it
	function automatic logic [15:0] pick_sample();
		int r;
		int k;
		int off;
		int t;
		r = $urandom_range(99);
		if (r < 12) return lvl;
		if (r < 70) begin
			k   = $urandom_range(15);
			off = $urandom_range(1 << k, 0);
			if ($urandom_range(1)) off = -off;
			t = int'(lvl) + off;
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			return t[15:0];
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_level();
		int r;
		r = $urandom_range(3);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'($urandom_range(1023) - 512);
		return 16'($urandom);
	endfunction

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 38);
	end

	// one output transaction per rising edge with valid and ready
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				report("point with none pending", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_points.pop_front();
				if (m_tdata[CW-1:0] !== want.col_whole)
					report("col_whole", 32'(m_tdata[CW-1:0]), 32'(want.col_whole));
				if (m_tdata[CW+15:CW] !== want.col_frac)
					report("col_frac", 32'(m_tdata[CW+15:CW]), 32'(want.col_frac));
				if (m_tdata[CW+16+RW-1:CW+16] !== want.row_index)
					report("row_index", 32'(m_tdata[CW+16+RW-1:CW+16]), 32'(want.row_index));
				if (m_tuser !== want.kind)
					report("point_kind", 32'(m_tuser), 32'(want.kind));
				if (m_tlast !== want.last)
					report("last", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned len_v;
		int unsigned cnt_v;
		int          n_items;
		int          phase;
		logic [15:0] lvl_v;
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		calm       = 1'b0;
		fail_count = 0;
		samples_sent = 0;
		lvl       = '0;
		row_len_q = islc_pkg::DEF_ROW_LENGTH;
		row_cnt_q = islc_pkg::DEF_ROW_COUNT;
		prev_smp  = '0;
		col_ctr   = 0;
		row_ctr   = 0;

		// reset values: level 0, full-length rows
		add_known(16'h0100, 2'd1, mk_point('0, START_FRAC, '0, islc_pkg::KIND_START, 1'b1), '0);
		add_known(16'h0000, 2'd0, '0, '0);
		add_known(16'h8000, 2'd0, '0, '0);
		add_smp(16'h7FFF);
		add_smp(16'h8000);
		// single column rows, column counter left beyond the new length
		add_cfg(islc_pkg::REG_ROW_LENGTH, 16'd1);
		add_cfg(islc_pkg::REG_ROW_COUNT, 16'd2);
		add_smp(16'h0001);
		add_known(16'h0001, 2'd2, mk_point('0, START_FRAC, 10'd1, islc_pkg::KIND_START, 1'b0),
			mk_point('0, '0, 10'd1, islc_pkg::KIND_END, 1'b1));
		add_known(16'h0000, 2'd0, '0, '0);
		add_known(16'hFFFF, 2'd0, '0, '0);
		add_cfg(islc_pkg::REG_LEVEL, 16'h7FFF);
		add_known(16'h7FFF, 2'd0, '0, '0);
		add_known(16'h7FFE, 2'd0, '0, '0);
		add_cfg(islc_pkg::REG_LEVEL, 16'h8000);
		add_known(16'h8000, 2'd0, '0, '0);
		add_smp(16'h8001);
		add_cfg(islc_pkg::REG_LEVEL, 16'h0000);
		add_cfg(islc_pkg::REG_ROW_LENGTH, 16'd4);
		add_cfg(islc_pkg::REG_ROW_COUNT, 16'd3);
		add_smp(16'hFB00);
		add_smp(16'h0500);
		add_smp(16'hFB00);
		add_smp(16'h0500);
		for (int i = 0; i < 4; i++) add_smp(16'h0500);
		add_smp(16'h0001);
		add_smp(16'h0000);
		add_smp(16'hFFFF);
		add_smp(16'h0001);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				drain();
				cfg_write(stim_rows[i].sel, stim_rows[i].value);
			end else begin
				send_sample(stim_rows[i].value, stim_rows[i].known, stim_rows[i].known_n,
					stim_rows[i].k0, stim_rows[i].k1);
			end
		end

		phase = 0;
		while (samples_sent < RAND_ITEMS) begin
			case (phase)
				0: begin lvl_v = 16'h0000; len_v = 8;    cnt_v = 4;    n_items = 150; end
				1: begin lvl_v = 16'h7FFF; len_v = 1;    cnt_v = 1;    n_items = 60;  end
				2: begin lvl_v = pick_level(); len_v = 1024; cnt_v = 1024; n_items = 300; end
				3: begin lvl_v = 16'h8000; len_v = 0;    cnt_v = 0;    n_items = 60;  end
				4: begin lvl_v = pick_level(); len_v = 2047; cnt_v = 2047; n_items = 80; end
				default: begin
					lvl_v   = pick_level();
					len_v   = $urandom_range(24, 1);
					cnt_v   = $urandom_range(8, 1);
					n_items = $urandom_range(120, 40);
				end
			endcase
			drain();
			// no idling on either side for one long phase
			calm <= (phase == 2);
			cfg_write(islc_pkg::REG_LEVEL, lvl_v);
			cfg_write(islc_pkg::REG_ROW_LENGTH, 16'(len_v));
			cfg_write(islc_pkg::REG_ROW_COUNT, 16'(cnt_v));
			for (int k = 0; k < n_items; k++) begin
				if (phase == 0 && k == n_items / 2) drain();
				send_sample(pick_sample(), 1'b0, 2'd0, '0, '0);
				samples_sent++;
			end
			phase++;
		end

		drain();
		if (pending_points.size() != 0) begin
			report("points left over", 32'(pending_points.size()), 32'd0);
		end
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/islc_pkg.sv
sv/islc_div.sv
sv/iso_level_row_crossings.sv
test/tb_iso_level_row_crossings.sv
